// ===== hdl/saes_pkg.sv =====
// ---------------------------------------------------------------------------
// saes_pkg
// Types, constants and nibble functions shared by the S-AES core.
// ---------------------------------------------------------------------------
package saes_pkg;

   localparam int BlockWidth = 16;
   localparam int KeyWidth   = 16;

   localparam logic CMD_ENCRYPT = 1'b0;
   localparam logic CMD_DECRYPT = 1'b1;

   localparam logic [7:0] RCON_1 = 8'h80;
   localparam logic [7:0] RCON_2 = 8'h30;

   // mix columns matrices, forward [1 4;4 1] and inverse [9 2;2 9]
   localparam logic [3:0] MIX_DIAG     = 4'h1;
   localparam logic [3:0] MIX_OFF      = 4'h4;
   localparam logic [3:0] INV_MIX_DIAG = 4'h9;
   localparam logic [3:0] INV_MIX_OFF  = 4'h2;

   typedef struct packed {
      logic [BlockWidth-1:0] k0;
      logic [BlockWidth-1:0] k1;
      logic [BlockWidth-1:0] k2;
   } round_keys_type;

   function automatic logic [3:0] sbox(input logic [3:0] n);
      logic [3:0] r;
      case (n)
         4'h0: r = 4'h9;
         4'h1: r = 4'h4;
         4'h2: r = 4'hA;
         4'h3: r = 4'hB;
         4'h4: r = 4'hD;
         4'h5: r = 4'h1;
         4'h6: r = 4'h8;
         4'h7: r = 4'h5;
         4'h8: r = 4'h6;
         4'h9: r = 4'h2;
         4'hA: r = 4'h0;
         4'hB: r = 4'h3;
         4'hC: r = 4'hC;
         4'hD: r = 4'hE;
         4'hE: r = 4'hF;
         default: r = 4'h7;
      endcase
      return r;
   endfunction

   function automatic logic [3:0] inv_sbox(input logic [3:0] n);
      logic [3:0] r;
      case (n)
         4'h0: r = 4'hA;
         4'h1: r = 4'h5;
         4'h2: r = 4'h9;
         4'h3: r = 4'hB;
         4'h4: r = 4'h1;
         4'h5: r = 4'h7;
         4'h6: r = 4'h8;
         4'h7: r = 4'hF;
         4'h8: r = 4'h6;
         4'h9: r = 4'h0;
         4'hA: r = 4'h2;
         4'hB: r = 4'h3;
         4'hC: r = 4'hC;
         4'hD: r = 4'h4;
         4'hE: r = 4'hD;
         default: r = 4'hE;
      endcase
      return r;
   endfunction

   function automatic logic [15:0] sub_nib(input logic [15:0] x);
      return {sbox(x[15:12]), sbox(x[11:8]), sbox(x[7:4]), sbox(x[3:0])};
   endfunction

   function automatic logic [15:0] inv_sub_nib(input logic [15:0] x);
      return {inv_sbox(x[15:12]), inv_sbox(x[11:8]), inv_sbox(x[7:4]), inv_sbox(x[3:0])};
   endfunction

   // swaps the second and fourth nibbles, self-inverse
   function automatic logic [15:0] shift_rows(input logic [15:0] x);
      return {x[15:12], x[3:0], x[7:4], x[11:8]};
   endfunction

   // multiply in GF(16) modulo x^4+x+1
   function automatic logic [3:0] gf_mul(input logic [3:0] a, input logic [3:0] b);
      logic [4:0] aa;
      logic [3:0] bb;
      logic [3:0] acc;
      aa  = {1'b0, a};
      bb  = b;
      acc = '0;
      for (int i = 0; i < 4; i++) begin
         if (bb[0]) begin
            acc = acc ^ aa[3:0];
         end
         bb = bb >> 1;
         aa = aa << 1;
         if (aa[4]) begin
            aa = aa ^ 5'h13;
         end
      end
      return acc;
   endfunction

   function automatic logic [15:0] mix_cols(input logic [15:0] x, input logic [3:0] diag,
                                            input logic [3:0] off);
      logic [3:0] r0;
      logic [3:0] r1;
      logic [3:0] r2;
      logic [3:0] r3;
      r0 = gf_mul(diag, x[15:12]) ^ gf_mul(off, x[11:8]);
      r1 = gf_mul(off, x[15:12]) ^ gf_mul(diag, x[11:8]);
      r2 = gf_mul(diag, x[7:4]) ^ gf_mul(off, x[3:0]);
      r3 = gf_mul(off, x[7:4]) ^ gf_mul(diag, x[3:0]);
      return {r0, r1, r2, r3};
   endfunction

   // rotnib then subnib on one key word
   function automatic logic [7:0] word_fn(input logic [7:0] w);
      return {sbox(w[3:0]), sbox(w[7:4])};
   endfunction

   function automatic round_keys_type key_expand(input logic [KeyWidth-1:0] key);
      logic [7:0] w0;
      logic [7:0] w1;
      logic [7:0] w2;
      logic [7:0] w3;
      logic [7:0] w4;
      logic [7:0] w5;
      round_keys_type rk;
      w0 = key[15:8];
      w1 = key[7:0];
      w2 = w0 ^ RCON_1 ^ word_fn(w1);
      w3 = w2 ^ w1;
      w4 = w2 ^ RCON_2 ^ word_fn(w3);
      w5 = w4 ^ w3;
      rk.k0 = {w0, w1};
      rk.k1 = {w2, w3};
      rk.k2 = {w4, w5};
      return rk;
   endfunction

endpackage

// ===== hdl/simplified_aes_block_cipher_core.sv =====
// ---------------------------------------------------------------------------
// simplified_aes_block_cipher_core
// S-AES on 16-bit blocks, encrypt or decrypt, three-stage pipeline.
// ---------------------------------------------------------------------------
// Usage:
//   csr_we/csr_wdata load the 16-bit cipher key; the round keys are
//   expanded at the write edge and are in use from the next cycle on.
//   Write the key only while no block is in flight.
//   A block transfer happens at a clock edge with start high and busy low;
//   req_cmd selects encrypt (0) or decrypt (1), req_block_in is the block.
//   busy stays low: a new block may be started every cycle.
//   Each block gives one result on rsp_block_out, marked by rsp_valid for
//   a single cycle, after its pass through the stage registers. Throughput
//   is one block per cycle, set by the three round stages (initial key add
//   and first round, mix columns, final round), each one register deep.
//   Results come out in start order. The receiver cannot stall, so the
//   pipeline never holds.
//   Reset (synchronous, active high) empties the pipeline and returns the
//   key to zero.
// ---------------------------------------------------------------------------
module simplified_aes_block_cipher_core
   import saes_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_cmd,
   input  logic [BlockWidth-1:0] req_block_in,
   output logic                  rsp_valid,
   output logic [BlockWidth-1:0] rsp_block_out,
   input  logic                  csr_we,
   input  logic [KeyWidth-1:0]   csr_wdata
);

   round_keys_type round_keys;

   logic                  v1_ff, v2_ff, v3_ff;
   logic                  v1_in, v2_in, v3_in;
   logic                  cmd1_ff, cmd2_ff;
   logic [BlockWidth-1:0] d1_ff, d2_ff, d3_ff;
   logic [BlockWidth-1:0] d1_in, d2_in, d3_in;
   logic                  accept;

   saes_key_sched u_key_sched (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .round_keys (round_keys)
   );

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   assign v1_in = accept;
   assign v2_in = v1_ff;
   assign v3_in = v2_ff;

   // stage 1: key add, first substitution layer and shift rows (decrypt also adds k1)
   always_comb begin
      if (req_cmd == CMD_DECRYPT) begin
         d1_in = inv_sub_nib(shift_rows(req_block_in ^ round_keys.k2)) ^ round_keys.k1;
      end else begin
         d1_in = shift_rows(sub_nib(req_block_in ^ round_keys.k0));
      end
   end

   // stage 2: mix columns (encrypt then adds k1)
   always_comb begin
      if (cmd1_ff == CMD_DECRYPT) begin
         d2_in = mix_cols(d1_ff, INV_MIX_DIAG, INV_MIX_OFF);
      end else begin
         d2_in = mix_cols(d1_ff, MIX_DIAG, MIX_OFF) ^ round_keys.k1;
      end
   end

   // stage 3: last round
   always_comb begin
      if (cmd2_ff == CMD_DECRYPT) begin
         d3_in = inv_sub_nib(shift_rows(d2_ff)) ^ round_keys.k0;
      end else begin
         d3_in = shift_rows(sub_nib(d2_ff)) ^ round_keys.k2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd1_ff <= req_cmd;
      cmd2_ff <= cmd1_ff;
      d1_ff   <= d1_in;
      d2_ff   <= d2_in;
      d3_ff   <= d3_in;
   end

   assign rsp_valid     = v3_ff;
   assign rsp_block_out = d3_ff;

   a_rsp_from_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 3))
      else $error("result without a start three cycles earlier");

   a_valid_chain: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> $past(v2_ff) && $past(v1_ff, 2))
      else $error("pipeline valid bits out of step");

   a_key_load: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> round_keys.k0 == $past(csr_wdata))
      else $error("round key 0 does not follow the key write");

   a_cmd_follows: assert property (@(posedge clock) disable iff (reset)
      v1_ff |=> cmd2_ff == $past(cmd1_ff))
      else $error("command lost between stages");

endmodule

// ===== hdl/saes_key_sched.sv =====
// ---------------------------------------------------------------------------
// saes_key_sched
// Holds the expanded round keys; expansion happens on each key write.
// ---------------------------------------------------------------------------
module saes_key_sched
   import saes_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [KeyWidth-1:0] csr_wdata,
   output round_keys_type      round_keys
);

   round_keys_type rk_ff;
   round_keys_type rk_in;

   always_comb begin
      rk_in = rk_ff;
      if (csr_we) begin
         rk_in = key_expand(csr_wdata);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rk_ff <= key_expand('0);
      end else begin
         rk_ff <= rk_in;
      end
   end

   assign round_keys = rk_ff;

endmodule

// ===== bench/cipher_checker.sv =====
// ---------------------------------------------------------------------------
// cipher_checker
// Watches the block, key and result ports of the S-AES core, keeps its own
// copy of the cipher key, predicts each result from every block transfer and
// compares the results in order; counts failures for the testbench top.
// ---------------------------------------------------------------------------
module cipher_checker
   import saes_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  logic                  req_cmd,
   input  logic [BlockWidth-1:0] req_block_in,
   input  logic                  rsp_valid,
   input  logic [BlockWidth-1:0] rsp_block_out,
   input  logic                  csr_we,
   input  logic [KeyWidth-1:0]   csr_wdata,
   output int unsigned           fail_count,
   output int unsigned           in_flight
);

   // nibble n of the substitution box sits at bits [4n+3:4n]
   localparam logic [63:0] SBOX_NIBBLES     = 64'h7FEC_3026_581D_BA49;
   localparam logic [63:0] INV_SBOX_NIBBLES = 64'hED4C_3206_F871_B95A;

   localparam logic [7:0] ROUND_CONST_1 = 8'h80;
   localparam logic [7:0] ROUND_CONST_2 = 8'h30;

   localparam logic [3:0] FWD_DIAG = 4'h1;
   localparam logic [3:0] FWD_OFF  = 4'h4;
   localparam logic [3:0] INV_DIAG = 4'h9;
   localparam logic [3:0] INV_OFF  = 4'h2;

   logic [KeyWidth-1:0]   cipher_key;
   logic [BlockWidth-1:0] expected_blocks[$];

   function automatic logic [15:0] substitute(input logic [15:0] x, input logic [63:0] lut);
      logic [15:0] r;
      int          nib;
      for (int i = 0; i < 4; i++) begin
         nib          = x[4*i +: 4];
         r[4*i +: 4] = lut[4*nib +: 4];
      end
      return r;
   endfunction

   function automatic logic [15:0] swap_nibbles(input logic [15:0] x);
      return {x[15:12], x[3:0], x[7:4], x[11:8]};
   endfunction

   // horner form, x^4 folds back to x+1
   function automatic logic [3:0] gf16_mul(input logic [3:0] a, input logic [3:0] b);
      logic [3:0] acc;
      acc = 4'h0;
      for (int i = 3; i >= 0; i--) begin
         acc = {acc[2:0], 1'b0} ^ (acc[3] ? 4'h3 : 4'h0);
         if (b[i]) begin
            acc = acc ^ a;
         end
      end
      return acc;
   endfunction

   function automatic logic [15:0] column_mix(input logic [15:0] x, input logic [3:0] d,
                                              input logic [3:0] o);
      return {gf16_mul(d, x[15:12]) ^ gf16_mul(o, x[11:8]),
              gf16_mul(o, x[15:12]) ^ gf16_mul(d, x[11:8]),
              gf16_mul(d, x[7:4])   ^ gf16_mul(o, x[3:0]),
              gf16_mul(o, x[7:4])   ^ gf16_mul(d, x[3:0])};
   endfunction

   function automatic logic [7:0] key_word(input logic [7:0] w);
      logic [15:0] subbed;
      subbed = substitute({8'h00, w[3:0], w[7:4]}, SBOX_NIBBLES);
      return subbed[7:0];
   endfunction

   function automatic logic [BlockWidth-1:0] saes_predict(input logic cmd,
                                                          input logic [BlockWidth-1:0] blk,
                                                          input logic [KeyWidth-1:0] key);
      logic [7:0]  w2;
      logic [7:0]  w3;
      logic [7:0]  w4;
      logic [7:0]  w5;
      logic [15:0] k1;
      logic [15:0] k2;
      logic [15:0] x;
      w2 = key[15:8] ^ ROUND_CONST_1 ^ key_word(key[7:0]);
      w3 = w2 ^ key[7:0];
      w4 = w2 ^ ROUND_CONST_2 ^ key_word(w3);
      w5 = w4 ^ w3;
      k1 = {w2, w3};
      k2 = {w4, w5};
      if (cmd == CMD_DECRYPT) begin
         x = blk ^ k2;
         x = substitute(swap_nibbles(x), INV_SBOX_NIBBLES) ^ k1;
         x = column_mix(x, INV_DIAG, INV_OFF);
         x = substitute(swap_nibbles(x), INV_SBOX_NIBBLES) ^ key;
      end else begin
         x = blk ^ key;
         x = column_mix(swap_nibbles(substitute(x, SBOX_NIBBLES)), FWD_DIAG, FWD_OFF) ^ k1;
         x = swap_nibbles(substitute(x, SBOX_NIBBLES)) ^ k2;
      end
      return x;
   endfunction

   always @(posedge clock) begin
      logic [BlockWidth-1:0] want;
      if (reset) begin
         cipher_key = '0;
         expected_blocks.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_blocks.size() == 0) begin
               $error("unexpected result transfer: block_out %h", rsp_block_out);
               fail_count++;
            end else begin
               want = expected_blocks.pop_front();
               if (rsp_block_out !== want) begin
                  $error("block_out mismatch: expected %h, actual %h", want, rsp_block_out);
                  fail_count++;
               end
            end
         end
         // predict with the key in use before any write at this edge
         if (start && !busy) begin
            expected_blocks.insert(expected_blocks.size(),
                                   saes_predict(req_cmd, req_block_in, cipher_key));
         end
         if (csr_we) begin
            cipher_key = csr_wdata;
         end
      end
      in_flight = expected_blocks.size();
   end

endmodule

// ===== bench/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Drives the S-AES core with directed and random encrypt/decrypt blocks
// under several keys and random sender gaps; the checker predicts and
// compares every result, a watchdog guards against a hang.
// ---------------------------------------------------------------------------
module testbench;
   import saes_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int PHASE_COUNT    = 10;
   localparam int PHASE_BLOCKS   = 100;

   typedef enum int {
      GAP_NONE,
      GAP_RANDOM,
      GAP_BURSTY
   } gap_mode_type;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic                  req_cmd;
   logic [BlockWidth-1:0] req_block_in;
   logic                  rsp_valid;
   logic [BlockWidth-1:0] rsp_block_out;
   logic                  csr_we;
   logic [KeyWidth-1:0]   csr_wdata;
   int unsigned           fail_count;
   int unsigned           in_flight;
   int unsigned           quiet_cycles;

   logic [BlockWidth-1:0] sweep_blocks[6] = '{16'h0000, 16'hFFFF, 16'h0123,
                                              16'h4567, 16'h89AB, 16'hCDEF};

   simplified_aes_block_cipher_core DUT (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_cmd       (req_cmd),
      .req_block_in  (req_block_in),
      .rsp_valid     (rsp_valid),
      .rsp_block_out (rsp_block_out),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata)
   );

   cipher_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_cmd       (req_cmd),
      .req_block_in  (req_block_in),
      .rsp_valid     (rsp_valid),
      .rsp_block_out (rsp_block_out),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .in_flight     (in_flight)
   );

   initial begin
      clock = 1'b0;
   end

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   function automatic int draw_gap(input gap_mode_type mode);
      case (mode)
         GAP_RANDOM: begin
            return $urandom_range(0, 15);
         end
         GAP_BURSTY: begin
            return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
         end
         default: begin
            return 0;
         end
      endcase
   endfunction

   // one block transfer; start stays high on return
   task automatic send_block(input logic cmd, input logic [BlockWidth-1:0] blk, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start        <= 1'b1;
      req_cmd      <= cmd;
      req_block_in <= blk;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // hold off until every expected result has been seen
   task automatic drain_pipeline;
      start <= 1'b0;
      do @(negedge clock); while (in_flight != 0);
      @(posedge clock);
   endtask

   task automatic load_key(input logic [KeyWidth-1:0] key);
      drain_pipeline();
      csr_we    <= 1'b1;
      csr_wdata <= key;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin
      gap_mode_type          mode;
      logic [KeyWidth-1:0]   key;
      logic [BlockWidth-1:0] blk;

      reset        <= 1'b1;
      start        <= 1'b0;
      req_cmd      <= CMD_ENCRYPT;
      req_block_in <= '0;
      csr_we       <= 1'b0;
      csr_wdata    <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset key: extremes and a sweep over every nibble value, both ways
      foreach (sweep_blocks[i]) begin
         send_block(CMD_ENCRYPT, sweep_blocks[i], 0);
         send_block(CMD_DECRYPT, sweep_blocks[i], draw_gap(GAP_BURSTY));
      end

      // textbook key and pair
      load_key(16'h4AF5);
      send_block(CMD_ENCRYPT, 16'hD728, 0);
      send_block(CMD_DECRYPT, 16'h24EC, 0);

      load_key(16'hFFFF);
      send_block(CMD_ENCRYPT, 16'h0000, 0);
      send_block(CMD_ENCRYPT, 16'hFFFF, 1);
      send_block(CMD_DECRYPT, 16'h0000, 0);
      send_block(CMD_DECRYPT, 16'hFFFF, 2);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase == 0) begin
            key = 16'h0000;
         end else if (phase == 1) begin
            key = 16'hFFFF;
         end else begin
            key = KeyWidth'($urandom);
         end
         load_key(key);
         mode = gap_mode_type'(phase % 3);
         for (int n = 0; n < PHASE_BLOCKS; n++) begin
            if ($urandom_range(0, 15) == 0) begin
               blk = {BlockWidth{1'($urandom_range(0, 1))}};
            end else begin
               blk = BlockWidth'($urandom);
            end
            send_block(1'($urandom_range(0, 1)), blk, draw_gap(mode));
            if (mode == GAP_RANDOM && $urandom_range(0, 49) == 0) begin
               drain_pipeline();
            end
         end
      end

      drain_pipeline();
      repeat (6) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/saes_pkg.sv
hdl/saes_key_sched.sv
hdl/simplified_aes_block_cipher_core.sv
bench/cipher_checker.sv
bench/testbench.sv
